/* rtl/stsub_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_pkg: shared types and constants
// corner and triangle words, cordic angle table, vertex emission order
// ----------------------------------------------------------------------------
package stsub_pkg;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [17:0] u;
    logic signed [17:0] v;
  } corner_t;

  typedef struct packed {
    corner_t c2;
    corner_t c1;
    corner_t c0;
  } triangle_t;

  localparam logic [23:0] RADIUS_RESET = 24'd65536;

  // arctan table in units of 2^-24 turn
  localparam int CORDIC_STEPS = 18;
  localparam logic [21:0] TURN_TAB [CORDIC_STEPS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
    22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304,
    22'd652, 22'd326, 22'd163, 22'd81, 22'd41, 22'd20
  };

  localparam logic signed [26:0] HALF_TURN = 27'sd8388608;

  // vertex slots: 0..2 corners, 3 = mid(0,2), 4 = mid(0,1), 5 = mid(1,2)
  localparam int EMIT_COUNT = 12;
  localparam logic [2:0] EMIT_ORDER [EMIT_COUNT] = '{
    3'd4, 3'd1, 3'd5, 3'd0, 3'd4, 3'd3, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd2
  };

endpackage

/* rtl/stsub_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_if: channel interfaces
// corner input words, vertex output words and the radius write channel
// ----------------------------------------------------------------------------
interface stsub_corner_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_normal_x;
  logic signed [15:0] in_normal_y;
  logic signed [15:0] in_normal_z;
  logic signed [17:0] in_tex_u;
  logic signed [17:0] in_tex_v;
  modport source (output valid, in_normal_x, in_normal_y, in_normal_z, in_tex_u, in_tex_v,
                  input ready);
  modport sink (input valid, in_normal_x, in_normal_y, in_normal_z, in_tex_u, in_tex_v,
                output ready);
endinterface

interface stsub_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] out_pos_x;
  logic signed [25:0] out_pos_y;
  logic signed [25:0] out_pos_z;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic signed [15:0] out_normal_z;
  logic signed [17:0] out_tex_u;
  logic signed [17:0] out_tex_v;
  logic [15:0]        out_index;
  logic               last_of_run;
  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_normal_x, out_normal_y,
                  out_normal_z, out_tex_u, out_tex_v, out_index, last_of_run,
                  input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_normal_x, out_normal_y,
                out_normal_z, out_tex_u, out_tex_v, out_index, last_of_run,
                output ready);
endinterface

interface stsub_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] radius;
  modport source (output valid, radius, input ready);
  modport sink (input valid, radius, output ready);
endinterface

/* rtl/stsub_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_front: corner collector
// holds the first two corners, pushes a whole triangle on the third
// ----------------------------------------------------------------------------
module stsub_front (
  input  logic                  clk,
  input  logic                  rst,
  stsub_corner_if.sink          corner,
  output logic                  push,
  output stsub_pkg::triangle_t  tri_data,
  input  logic                  full
);
  import stsub_pkg::*;

  logic [1:0] count;
  corner_t    held [2];
  corner_t    cur;
  logic       accept;

  assign cur = '{nx: corner.in_normal_x, ny: corner.in_normal_y, nz: corner.in_normal_z,
                 u: corner.in_tex_u, v: corner.in_tex_v};

  // third corner waits only when the queue is full
  assign corner.ready = (count != 2'd2) || !full;
  assign accept       = corner.valid && corner.ready;
  assign push         = accept && (count == 2'd2);
  assign tri_data     = '{c2: cur, c1: held[1], c0: held[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (count == 2'd2) begin
        count <= 2'd0;
      end else begin
        held[count[0]] <= cur;
        count          <= count + 2'd1;
      end
    end
  end

endmodule

/* rtl/stsub_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_fifo: triangle queue
// two-entry queue between corner collector and vertex engine
// ----------------------------------------------------------------------------
module stsub_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  stsub_pkg::triangle_t  wdata,
  output logic                  full,
  output logic                  avail,
  output stsub_pkg::triangle_t  rdata,
  input  logic                  pop
);
  import stsub_pkg::*;

  triangle_t  mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wp] <= wdata;
        wp      <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full triangle queue");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("pop from empty triangle queue");
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("triangle queue count lost a push");

endmodule

/* rtl/stsub_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_back: vertex engine
// midpoint normals, texcoords and positions, then twelve vertex words
// ----------------------------------------------------------------------------
module stsub_back #(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [23:0]           radius,
  input  logic                  tri_valid,
  input  stsub_pkg::triangle_t  tri_data,
  output logic                  tri_pop,
  stsub_vertex_if.source        vertex
);
  import stsub_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_SUM_A, B_SUM_B, B_SQ, B_SQRT, B_DIV_INIT, B_DIV_STEP, B_ANG_INIT,
    B_ANG_STEP, B_ANG_FIN, B_YSQ, B_WSTART, B_POS_MUL, B_POS_WR, B_EMIT
  } state_t;

  state_t state;

  // vertex table
  logic signed [15:0] tn [6][3];
  logic signed [17:0] tu [6];
  logic signed [17:0] tv [6];
  logic signed [25:0] tp [6][3];

  logic [1:0]  m;
  logic [1:0]  k;
  logic [2:0]  pv;
  logic [1:0]  pc;
  logic [3:0]  ek;

  logic signed [16:0] s [3];
  logic [33:0]        len2;
  logic [30:0]        len;
  logic signed [15:0] mn [3];
  logic signed [17:0] mu;
  logic signed [15:0] yc;
  logic [29:0]        ysq;
  logic [14:0]        w;

  // shared square root
  logic [63:0] sq_x;
  logic [63:0] sq_r;
  logic [63:0] sq_b;
  logic [4:0]  sq_cnt;
  logic        sq_sel;

  // shared divider
  logic [45:0] dv_rem;
  logic [45:0] dv_d;
  logic [14:0] dv_q;
  logic [3:0]  dv_cnt;

  // shared cordic
  logic signed [27:0] cx;
  logic signed [27:0] cz;
  logic signed [26:0] ca;
  logic [4:0]         c_cnt;
  logic               c_sel;

  logic signed [40:0] prod;

  // output register
  logic                  ov;
  logic signed [25:0]    o_pos [3];
  logic signed [15:0]    o_n [3];
  logic signed [17:0]    o_u;
  logic signed [17:0]    o_v;
  logic [15:0]           o_index;
  logic                  o_last;
  logic [INDEX_BITS-1:0] cnt;

  // table read port
  logic [2:0]         rd_addr;
  logic signed [15:0] rd_n [3];
  logic               load;

  always_comb begin
    case (state)
      B_SUM_A:   rd_addr = (m == 2'd2) ? 3'd1 : 3'd0;
      B_SUM_B:   rd_addr = (m == 2'd1) ? 3'd1 : 3'd2;
      B_POS_MUL: rd_addr = pv;
      default:   rd_addr = EMIT_ORDER[ek];
    endcase
  end

  assign rd_n[0] = tn[rd_addr][0];
  assign rd_n[1] = tn[rd_addr][1];
  assign rd_n[2] = tn[rd_addr][2];

  assign load    = (state == B_EMIT) && (!ov || vertex.ready);
  assign tri_pop = (state == B_IDLE) && tri_valid;

  // square accumulate
  logic signed [33:0] sq_term;
  logic [33:0]        len2_next;
  assign sq_term   = s[k] * s[k];
  assign len2_next = len2 + sq_term[33:0];

  // sqrt step
  logic [63:0] sq_sum;
  logic        sq_ge;
  logic [63:0] sq_r_next;
  assign sq_sum    = sq_r + sq_b;
  assign sq_ge     = sq_x >= sq_sum;
  assign sq_r_next = sq_ge ? ((sq_r >> 1) + sq_b) : (sq_r >> 1);

  // divider setup and step
  logic [16:0]        mag;
  logic [45:0]        num;
  logic [45:0]        lim;
  logic               dv_ge;
  logic [14:0]        q_next;
  logic signed [15:0] q_s;
  assign mag    = s[k][16] ? 17'(-s[k]) : 17'(s[k]);
  assign num    = 46'({mag, 28'd0}) + 46'(len[30:1]);
  assign lim    = {len, 15'd0};
  assign dv_ge  = dv_rem >= dv_d;
  assign q_next = {dv_q[13:0], dv_ge};
  assign q_s    = $signed({1'b0, q_next});

  // cordic setup and step
  logic signed [15:0] ix;
  logic signed [15:0] iz;
  logic signed [27:0] ex;
  logic signed [27:0] ez;
  logic signed [27:0] dx;
  logic signed [27:0] dz;
  logic signed [26:0] tab;
  assign ix  = c_sel ? yc : mn[0];
  assign iz  = c_sel ? $signed({1'b0, w}) : mn[2];
  assign ex  = 28'(ix) <<< 8;
  assign ez  = 28'(iz) <<< 8;
  assign dx  = cz >>> c_cnt;
  assign dz  = cx >>> c_cnt;
  assign tab = $signed({5'd0, TURN_TAB[c_cnt]});

  // angle to texcoord
  logic signed [26:0] ua;
  logic signed [18:0] us;
  logic signed [17:0] u_cl;
  logic signed [26:0] va;
  logic signed [19:0] vs;
  logic signed [17:0] v_cl;
  assign ua = ca + 27'sd128;
  assign us = 19'(ua >>> 8);
  assign va = ca + 27'sd64;
  assign vs = 20'(va >>> 7);
  always_comb begin
    if (us < -19'sd32768)     u_cl = -18'sd32768;
    else if (us > 19'sd32768) u_cl = 18'sd32768;
    else                      u_cl = 18'(us);
    if (vs < 20'sd0)          v_cl = 18'sd0;
    else if (vs > 20'sd65536) v_cl = 18'sd65536;
    else                      v_cl = 18'(vs);
  end

  // clamped y and its square
  logic signed [15:0] y_cl;
  logic signed [31:0] y_prod;
  always_comb begin
    if (mn[1] < -16'sd16384)     y_cl = -16'sd16384;
    else if (mn[1] > 16'sd16384) y_cl = 16'sd16384;
    else                         y_cl = mn[1];
  end
  assign y_prod = y_cl * y_cl;

  // position rounding
  logic signed [40:0] pr;
  logic signed [25:0] p_cl;
  assign pr = (prod + 41'sd8192) >>> 14;
  always_comb begin
    if (pr < -41'sd16777216)     p_cl = -26'sd16777216;
    else if (pr > 41'sd16777216) p_cl = 26'sd16777216;
    else                         p_cl = 26'(pr);
  end

  logic [INDEX_BITS+15:0] cnt_ext;
  assign cnt_ext = {16'd0, cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ov     <= 1'b0;
      cnt    <= '0;
      ek     <= 4'd0;
      m      <= 2'd0;
      k      <= 2'd0;
      pv     <= 3'd0;
      pc     <= 2'd0;
      sq_cnt <= 5'd0;
      sq_sel <= 1'b0;
      dv_cnt <= 4'd0;
      c_cnt  <= 5'd0;
      c_sel  <= 1'b0;
    end else begin
      if (load) begin
        ov       <= 1'b1;
        o_pos[0] <= tp[rd_addr][0];
        o_pos[1] <= tp[rd_addr][1];
        o_pos[2] <= tp[rd_addr][2];
        o_n[0]   <= rd_n[0];
        o_n[1]   <= rd_n[1];
        o_n[2]   <= rd_n[2];
        o_u      <= tu[rd_addr];
        o_v      <= tv[rd_addr];
        o_index  <= cnt_ext[15:0];
        o_last   <= (ek == 4'(EMIT_COUNT - 1));
        cnt      <= cnt + 1'b1;
      end else if (vertex.ready) begin
        ov <= 1'b0;
      end

      case (state)
        B_IDLE: begin
          if (tri_valid) begin
            tn[0][0] <= tri_data.c0.nx;
            tn[0][1] <= tri_data.c0.ny;
            tn[0][2] <= tri_data.c0.nz;
            tu[0]    <= tri_data.c0.u;
            tv[0]    <= tri_data.c0.v;
            tn[1][0] <= tri_data.c1.nx;
            tn[1][1] <= tri_data.c1.ny;
            tn[1][2] <= tri_data.c1.nz;
            tu[1]    <= tri_data.c1.u;
            tv[1]    <= tri_data.c1.v;
            tn[2][0] <= tri_data.c2.nx;
            tn[2][1] <= tri_data.c2.ny;
            tn[2][2] <= tri_data.c2.nz;
            tu[2]    <= tri_data.c2.u;
            tv[2]    <= tri_data.c2.v;
            m        <= 2'd0;
            state    <= B_SUM_A;
          end
        end
        B_SUM_A: begin
          s[0]  <= 17'(rd_n[0]);
          s[1]  <= 17'(rd_n[1]);
          s[2]  <= 17'(rd_n[2]);
          state <= B_SUM_B;
        end
        B_SUM_B: begin
          s[0]  <= s[0] + 17'(rd_n[0]);
          s[1]  <= s[1] + 17'(rd_n[1]);
          s[2]  <= s[2] + 17'(rd_n[2]);
          k     <= 2'd0;
          len2  <= 34'd0;
          state <= B_SQ;
        end
        B_SQ: begin
          len2 <= len2_next;
          if (k == 2'd2) begin
            k <= 2'd0;
            if (len2_next == 34'd0) begin
              // zero or opposite corners: normal stays zero
              mn[0] <= 16'sd0;
              mn[1] <= 16'sd0;
              mn[2] <= 16'sd0;
              c_sel <= 1'b0;
              state <= B_ANG_INIT;
            end else begin
              sq_x   <= 64'({len2_next, 28'd0});
              sq_r   <= 64'd0;
              sq_b   <= 64'd1 << 62;
              sq_cnt <= 5'd31;
              sq_sel <= 1'b0;
              state  <= B_SQRT;
            end
          end else begin
            k <= k + 2'd1;
          end
        end
        B_SQRT: begin
          if (sq_ge) begin
            sq_x <= sq_x - sq_sum;
          end
          sq_r   <= sq_r_next;
          sq_b   <= sq_b >> 2;
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == 5'd0) begin
            if (sq_sel) begin
              w     <= sq_r_next[14:0];
              c_sel <= 1'b1;
              state <= B_ANG_INIT;
            end else begin
              len   <= sq_r_next[30:0];
              k     <= 2'd0;
              state <= B_DIV_INIT;
            end
          end
        end
        B_DIV_INIT: begin
          if (num >= lim) begin
            mn[k] <= s[k][16] ? -16'sd32767 : 16'sd32767;
            if (k == 2'd2) begin
              c_sel <= 1'b0;
              state <= B_ANG_INIT;
            end else begin
              k <= k + 2'd1;
            end
          end else begin
            dv_rem <= num;
            dv_d   <= {1'b0, len, 14'd0};
            dv_q   <= 15'd0;
            dv_cnt <= 4'd14;
            state  <= B_DIV_STEP;
          end
        end
        B_DIV_STEP: begin
          if (dv_ge) begin
            dv_rem <= dv_rem - dv_d;
          end
          dv_d   <= dv_d >> 1;
          dv_q   <= q_next;
          dv_cnt <= dv_cnt - 4'd1;
          if (dv_cnt == 4'd0) begin
            mn[k] <= s[k][16] ? -q_s : q_s;
            if (k == 2'd2) begin
              c_sel <= 1'b0;
              state <= B_ANG_INIT;
            end else begin
              k     <= k + 2'd1;
              state <= B_DIV_INIT;
            end
          end
        end
        B_ANG_INIT: begin
          c_cnt <= 5'd0;
          if (iz == 16'sd0) begin
            ca    <= (ix < 16'sd0) ? HALF_TURN : 27'sd0;
            state <= B_ANG_FIN;
          end else begin
            if (ix < 16'sd0) begin
              ca <= (iz > 16'sd0) ? HALF_TURN : -HALF_TURN;
              cx <= -ex;
              cz <= -ez;
            end else begin
              ca <= 27'sd0;
              cx <= ex;
              cz <= ez;
            end
            state <= B_ANG_STEP;
          end
        end
        B_ANG_STEP: begin
          if (cz >= 28'sd0) begin
            cx <= cx + dx;
            cz <= cz - dz;
            ca <= ca + tab;
          end else begin
            cx <= cx - dx;
            cz <= cz + dz;
            ca <= ca - tab;
          end
          c_cnt <= c_cnt + 5'd1;
          if (c_cnt == 5'(CORDIC_STEPS - 1)) begin
            state <= B_ANG_FIN;
          end
        end
        B_ANG_FIN: begin
          if (!c_sel) begin
            mu    <= u_cl;
            state <= B_YSQ;
          end else begin
            tn[3'(m) + 3'd3][0] <= mn[0];
            tn[3'(m) + 3'd3][1] <= mn[1];
            tn[3'(m) + 3'd3][2] <= mn[2];
            tu[3'(m) + 3'd3]    <= mu;
            tv[3'(m) + 3'd3]    <= v_cl;
            if (m == 2'd2) begin
              pv    <= 3'd0;
              pc    <= 2'd0;
              state <= B_POS_MUL;
            end else begin
              m     <= m + 2'd1;
              state <= B_SUM_A;
            end
          end
        end
        B_YSQ: begin
          yc    <= y_cl;
          ysq   <= y_prod[29:0];
          state <= B_WSTART;
        end
        B_WSTART: begin
          sq_x   <= 64'(30'd268435456 - ysq);
          sq_r   <= 64'd0;
          sq_b   <= 64'd1 << 62;
          sq_cnt <= 5'd31;
          sq_sel <= 1'b1;
          state  <= B_SQRT;
        end
        B_POS_MUL: begin
          prod  <= rd_n[pc] * $signed({1'b0, radius});
          state <= B_POS_WR;
        end
        B_POS_WR: begin
          tp[pv][pc] <= p_cl;
          if (pc == 2'd2) begin
            pc <= 2'd0;
            if (pv == 3'd5) begin
              ek    <= 4'd0;
              state <= B_EMIT;
            end else begin
              pv    <= pv + 3'd1;
              state <= B_POS_MUL;
            end
          end else begin
            pc    <= pc + 2'd1;
            state <= B_POS_MUL;
          end
        end
        B_EMIT: begin
          if (load) begin
            if (ek == 4'(EMIT_COUNT - 1)) begin
              ek    <= 4'd0;
              state <= B_IDLE;
            end else begin
              ek <= ek + 4'd1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign vertex.valid        = ov;
  assign vertex.out_pos_x    = o_pos[0];
  assign vertex.out_pos_y    = o_pos[1];
  assign vertex.out_pos_z    = o_pos[2];
  assign vertex.out_normal_x = o_n[0];
  assign vertex.out_normal_y = o_n[1];
  assign vertex.out_normal_z = o_n[2];
  assign vertex.out_tex_u    = o_u;
  assign vertex.out_tex_v    = o_v;
  assign vertex.out_index    = o_index;
  assign vertex.last_of_run  = o_last;

  a_index_step : assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == $past(cnt) + 1'b1)
    else $error("vertex index did not advance with a loaded word");
  a_run_end : assert property (@(posedge clk) disable iff (rst)
    (load && ek == 4'(EMIT_COUNT - 1)) |=> (state == B_IDLE && ov && o_last))
    else $error("twelfth vertex did not close the run");
  a_pop_idle : assert property (@(posedge clk) disable iff (rst)
    tri_pop |=> state == B_SUM_A && m == 2'd0)
    else $error("triangle taken without starting midpoint work");
  a_sqrt_end : assert property (@(posedge clk) disable iff (rst)
    (state == B_SQRT && sq_cnt == 5'd0) |=> state != B_SQRT)
    else $error("square root ran past its last step");

endmodule

/* rtl/sphere_triangle_subdivision.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_subdivision: midpoint subdivision of sphere triangles
// three corner words in, twelve vertex words out per triangle
// ----------------------------------------------------------------------------
// the first vertex word waits on the whole midpoint and position work of its triangle;
//   zero midpoints skip the first square root and the divider, clamped components the divider
// a triangle's pace is set by the shared square root (32 steps), divider (15 steps) and
//   18-step cordic, run in turn for each midpoint; the back end takes the next triangle
//   only after its twelve words; one vertex word per cycle on output while ready is high
// corners are taken at once while the two-entry triangle queue has room
// reset (rst, synchronous): queue, sequencer, vertex index cleared, radius 1.0
module sphere_triangle_subdivision #(
  parameter int INDEX_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  stsub_corner_if.sink   corner,
  stsub_vertex_if.source vertex,
  stsub_cfg_if.sink      cfg
);
  import stsub_pkg::*;

  // radius register, Q8.16; user writes only while the block is idle (unenforced)
  logic [23:0] radius;

  // front to queue
  logic      push;
  triangle_t push_data;
  logic      full;

  // queue to back end
  logic      tri_valid;
  triangle_t tri_data;
  logic      tri_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.radius;
    end
  end

  // collects corners, hands over whole triangles
  stsub_front u_front (
    .clk      (clk),
    .rst      (rst),
    .corner   (corner),
    .push     (push),
    .tri_data (push_data),
    .full     (full)
  );

  // decouples corner intake from the long vertex computation
  stsub_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .avail (tri_valid),
    .rdata (tri_data),
    .pop   (tri_pop)
  );

  // midpoints, texcoords, positions and the output word register
  stsub_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .tri_valid (tri_valid),
    .tri_data  (tri_data),
    .tri_pop   (tri_pop),
    .vertex    (vertex)
  );

endmodule
